FILE: rtl/cmta_pkg.sv
// Shared types, constants and helper functions for the color markup converter.
`timescale 1ns / 1ps

package cmta_pkg;

    localparam int unsigned MAX_LEN_RESET = 4096;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam int unsigned SEQ_MAX = 10;
    localparam int unsigned MAX_RESULTS = 11;

    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [5:0] BG_OFFSET  = 6'd10;

    localparam logic [5:0] COLOUR_TABLE [0:25] = '{
        6'd0, 6'd34, 6'd36, 6'd30, 6'd0, 6'd0, 6'd32, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd35,
        6'd0, 6'd0, 6'd0, 6'd0, 6'd31, 6'd0, 6'd0, 6'd0, 6'd0, 6'd37, 6'd0, 6'd33, 6'd0
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_AMP,
        MODE_FG,
        MODE_SLASH,
        MODE_DONE
    } t_mode;

    // One step's worth of work handed from the front to the back.
    typedef struct packed {
        logic       seq_en;
        logic       bold;
        logic [5:0] fg;
        logic       has_bg;
        logic [5:0] bg;
        logic       plain_en;
        logic [7:0] plain_byte;
        logic       marker;
        logic       str_last;
        logic       ovf;
    } t_cmd;

    typedef logic [SEQ_MAX-1:0][7:0] t_seq;

    // Number of bytes in an escape sequence.
    function automatic logic [3:0] seq_len(input logic [5:0] fg, input logic has_bg);
        logic [3:0] n;
        n = 4'd6;
        if (fg >= 6'd10) begin
            n = n + 4'd1;
        end
        if (has_bg) begin
            n = n + 4'd3;
        end
        return n;
    endfunction

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        t = 4'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= 6'(k * 10)) begin
                t = 4'(k);
            end
        end
        return t;
    endfunction

    function automatic logic [7:0] ones_char(input logic [5:0] v);
        logic [5:0] r;
        r = v - ({2'b00, tens_of(v)} * 6'd10);
        return CHAR_ZERO + {2'b00, r};
    endfunction

    function automatic logic [7:0] tens_char(input logic [5:0] v);
        return CHAR_ZERO + {4'b0000, tens_of(v)};
    endfunction

    // Bytes of the escape sequence, first byte at index 0.
    function automatic t_seq seq_bytes(input logic bold, input logic [5:0] fg,
                                       input logic has_bg, input logic [5:0] bg);
        t_seq s;
        logic [3:0] n;
        s = '0;
        s[0] = CHAR_ESC;
        s[1] = CHAR_LBRK;
        s[2] = bold ? CHAR_ONE : CHAR_ZERO;
        s[3] = CHAR_SEMI;
        n = 4'd4;
        if (fg >= 6'd10) begin
            s[n] = tens_char(fg);
            n = n + 4'd1;
        end
        s[n] = ones_char(fg);
        n = n + 4'd1;
        if (has_bg) begin
            s[n] = CHAR_SEMI;
            s[n + 4'd1] = tens_char(bg);
            s[n + 4'd2] = ones_char(bg);
            n = n + 4'd3;
        end
        s[n] = CHAR_M;
        return s;
    endfunction

endpackage

FILE: rtl/cmta_front.sv
// Front end: parses markup, tracks the output budget and issues at most one command per accepted byte.
`timescale 1ns / 1ps

module cmta_front
    import cmta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_max_len,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_mode      r_mode, n_mode;
    logic [5:0] r_fg, n_fg;
    logic       r_bold, n_bold;
    logic [15:0] r_cnt, n_cnt;
    logic       r_ovf, n_ovf;

    logic        is_upper, is_lower, is_letter;
    logic [4:0]  letter_idx;
    logic [5:0]  colour;
    t_mode       mid_mode;
    logic        seq_req, fresh_req, plain_req, has_bg;
    logic [5:0]  bg_val;
    logic        seq_en, plain_en;
    logic [16:0] seq_sum;
    logic [15:0] cnt_a, cnt_b;
    logic        ovf_a;
    t_mode       mode_a, mode_b;

    assign is_upper   = (i_byte >= CHAR_UA) && (i_byte <= CHAR_UZ);
    assign is_lower   = (i_byte >= CHAR_LA) && (i_byte <= CHAR_LZ);
    assign is_letter  = is_upper || is_lower;
    assign letter_idx = is_upper ? 5'(i_byte - CHAR_UA) : 5'(i_byte - CHAR_LA);
    assign colour     = is_letter ? COLOUR_TABLE[letter_idx] : 6'd0;

    // Tag parsing: decide what this byte asks for before the budget is applied.
    always_comb begin
        mid_mode  = r_mode;
        n_fg      = r_fg;
        n_bold    = r_bold;
        seq_req   = 1'b0;
        fresh_req = 1'b0;
        plain_req = 1'b0;
        has_bg    = 1'b0;
        bg_val    = colour + BG_OFFSET;
        unique case (r_mode)
            MODE_DONE: begin
            end
            MODE_AMP: begin
                mid_mode = MODE_IDLE;
                if (is_letter) begin
                    n_fg     = colour;
                    n_bold   = is_upper;
                    mid_mode = MODE_FG;
                end else begin
                    plain_req = 1'b1;
                end
            end
            MODE_FG: begin
                if (i_byte == CHAR_SLASH) begin
                    mid_mode = MODE_SLASH;
                end else begin
                    mid_mode  = MODE_IDLE;
                    seq_req   = 1'b1;
                    fresh_req = 1'b1;
                end
            end
            MODE_SLASH: begin
                mid_mode = MODE_IDLE;
                seq_req  = 1'b1;
                has_bg   = is_letter;
            end
            default: begin
                mid_mode  = MODE_IDLE;
                fresh_req = 1'b1;
            end
        endcase
        // A tag still open at the end of the string is flushed without background.
        if (i_last && (mid_mode == MODE_FG || mid_mode == MODE_SLASH)) begin
            seq_req = 1'b1;
            has_bg  = 1'b0;
        end
    end

    // Budget: the sequence first, then any plain byte.
    always_comb begin
        seq_en  = 1'b0;
        seq_sum = {1'b0, r_cnt} + 17'(seq_len(n_fg, has_bg));
        cnt_a   = r_cnt;
        ovf_a   = r_ovf;
        mode_a  = mid_mode;
        if (seq_req) begin
            if (seq_sum > {1'b0, i_max_len}) begin
                ovf_a = 1'b1;
            end else begin
                seq_en = 1'b1;
                cnt_a  = seq_sum[15:0];
            end
            if (cnt_a >= i_max_len) begin
                mode_a = MODE_DONE;
                ovf_a  = 1'b1;
            end
        end
        plain_en = plain_req;
        mode_b   = mode_a;
        if (fresh_req && mode_a != MODE_DONE) begin
            if (i_byte == CHAR_AMP) begin
                mode_b = MODE_AMP;
            end else begin
                plain_en = 1'b1;
            end
        end
        cnt_b = cnt_a;
        n_ovf = ovf_a;
        if (plain_en) begin
            cnt_b = cnt_a + 16'd1;
            if (cnt_b >= i_max_len) begin
                mode_b = MODE_DONE;
                n_ovf  = 1'b1;
            end
        end
        n_mode = mode_b;
        n_cnt  = cnt_b;
    end

    always_comb begin
        o_cmd.seq_en     = seq_en;
        o_cmd.bold       = n_bold;
        o_cmd.fg         = n_fg;
        o_cmd.has_bg     = has_bg;
        o_cmd.bg         = bg_val;
        o_cmd.plain_en   = plain_en;
        o_cmd.plain_byte = i_byte;
        o_cmd.marker     = i_last && !seq_en && !plain_en;
        o_cmd.str_last   = i_last;
        o_cmd.ovf        = n_ovf;
    end

    assign o_push = i_accept && (seq_en || plain_en || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_fg   <= '0;
            r_bold <= 1'b0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            r_fg   <= n_fg;
            r_bold <= n_bold;
            if (i_last) begin
                r_mode <= MODE_IDLE;
                r_cnt  <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_ovf  <= n_ovf;
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_cnt == '0 && !r_ovf && r_mode == MODE_IDLE))
        else $error("string end did not clear the front state");

    a_done_sets_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DONE) |-> r_ovf)
        else $error("limit reached without overflow flag");

    a_push_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cmd.seq_en || o_cmd.plain_en || o_cmd.marker))
        else $error("command pushed with nothing to emit");

endmodule

FILE: rtl/cmta_queue.sv
// Short command queue that decouples the parser from the byte emitter.
`timescale 1ns / 1ps

module cmta_queue
    import cmta_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count missed a push");

endmodule

FILE: rtl/cmta_back.sv
// Back end: expands each command into output bytes through a one-entry output register.
`timescale 1ns / 1ps

module cmta_back
    import cmta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_cmd,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_run_last,
    output logic       o_string_end,
    output logic       o_overflowed
);

    logic [3:0] r_pos;
    logic       r_full;
    logic [7:0] r_byte;
    logic       r_valid, r_run_last, r_str_end, r_ovf;

    t_seq       seq;
    logic [3:0] len, total;
    logic       load, at_end;
    logic [7:0] cur_byte;
    logic       cur_valid;

    assign seq   = seq_bytes(i_cmd.bold, i_cmd.fg, i_cmd.has_bg, i_cmd.bg);
    assign len   = i_cmd.seq_en ? seq_len(i_cmd.fg, i_cmd.has_bg) : 4'd0;
    assign total = len + {3'b000, i_cmd.plain_en} + {3'b000, i_cmd.marker};
    assign at_end = (r_pos == total - 4'd1);

    // Sequence bytes come first, then the plain byte, or the empty end marker.
    always_comb begin
        priority if (r_pos < len) begin
            cur_byte  = seq[r_pos];
            cur_valid = 1'b1;
        end else if (i_cmd.plain_en) begin
            cur_byte  = i_cmd.plain_byte;
            cur_valid = 1'b1;
        end else begin
            cur_byte  = 8'd0;
            cur_valid = 1'b0;
        end
    end

    assign load    = !i_q_empty && (!r_full || i_pop);
    assign o_q_pop = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_full <= 1'b0;
        end else begin
            if (load) begin
                r_pos  <= at_end ? 4'd0 : r_pos + 4'd1;
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= cur_byte;
            r_valid    <= cur_valid;
            r_run_last <= at_end;
            r_str_end  <= at_end && i_cmd.str_last;
            r_ovf      <= i_cmd.ovf;
        end
    end

    assign o_empty      = !r_full;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_valid;
    assign o_run_last   = r_run_last;
    assign o_string_end = r_str_end;
    assign o_overflowed = r_ovf;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < 4'(MAX_RESULTS))
        else $error("emitter position out of range");

    a_pos_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_empty |-> (r_pos == 4'd0))
        else $error("emitter stranded mid command");

    a_end_marks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_str_end) |-> r_run_last)
        else $error("string end without run end");

endmodule

FILE: rtl/color_markup_to_ansi_escape_core.sv
// Top level of the color markup to ANSI escape converter.
// The first result of a byte passes through the command queue and the output register to the result ports.
// One byte is accepted per cycle while the command queue (QUEUE_DEPTH entries) has room.
// Results leave one per cycle while pop is held; a byte causes from none up to 10 results (a tag with a
// background being longest), and input stalls only when pending commands fill the queue.
// Reset is synchronous and active low; it empties the queue and restores max_len to 4096.
`timescale 1ns / 1ps

module color_markup_to_ansi_escape_core
    import cmta_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_len,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_string_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_run_last,
    output logic        o_string_end,
    output logic        o_overflowed
);

    logic [15:0] r_max_len;
    logic        accept;
    logic        f_push, q_full, q_empty, q_pop;
    t_cmd        f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'(MAX_LEN_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_max_len;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    cmta_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_len (r_max_len),
        .i_accept  (accept),
        .i_byte    (i_in_byte),
        .i_last    (i_string_last),
        .o_push    (f_push),
        .o_cmd     (f_cmd)
    );

    cmta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    cmta_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_cmd        (q_cmd),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_string_end (o_string_end),
        .o_overflowed (o_overflowed)
    );

endmodule
